// ----- rtl/owb_pkg.sv -----
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types, codes and reset values for the single-wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

  localparam int REG_W          = 10;
  localparam int NUM_REGS       = 8;
  localparam int REG_IDX_W      = 3;
  localparam int BYTE_W         = 8;
  localparam int BIT_IDX_W      = 3;
  localparam int TIMER_BITS_DEF = 10;
  localparam int S_TDATA_W      = 16;
  localparam int M_TDATA_W      = 16;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_RESET = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RESET_LOW  = 3'd0,
    REG_PRES_WAIT  = 3'd1,
    REG_RESET_TAIL = 3'd2,
    REG_SHORT_LOW  = 3'd3,
    REG_W1_RELEASE = 3'd4,
    REG_W0_LOW     = 3'd5,
    REG_ZERO_REC   = 3'd6,
    REG_RD_WAIT    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_W1_LOW   = 4'd4,
    PH_W1_REL   = 4'd5,
    PH_W0_LOW   = 4'd6,
    PH_W0_REC   = 4'd7,
    PH_RD_LOW   = 4'd8,
    PH_RD_WAIT  = 4'd9,
    PH_RD_TAIL  = 4'd10
  } phase_t;

  localparam logic [REG_W-1:0] RST_RESET_LOW  = 10'd500;
  localparam logic [REG_W-1:0] RST_PRES_WAIT  = 10'd120;
  localparam logic [REG_W-1:0] RST_RESET_TAIL = 10'd380;
  localparam logic [REG_W-1:0] RST_SHORT_LOW  = 10'd2;
  localparam logic [REG_W-1:0] RST_W1_RELEASE = 10'd58;
  localparam logic [REG_W-1:0] RST_W0_LOW     = 10'd65;
  localparam logic [REG_W-1:0] RST_ZERO_REC   = 10'd2;
  localparam logic [REG_W-1:0] RST_RD_WAIT    = 10'd13;

  typedef struct packed {
    logic [REG_W-1:0] reset_low_time;
    logic [REG_W-1:0] presence_wait;
    logic [REG_W-1:0] reset_tail;
    logic [REG_W-1:0] short_low_time;
    logic [REG_W-1:0] write_one_release;
    logic [REG_W-1:0] write_zero_low;
    logic [REG_W-1:0] zero_recovery;
    logic [REG_W-1:0] read_sample_wait;
  } cfg_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence;
    logic [BYTE_W-1:0] rx_byte;
    logic              cmd_rejected;
  } result_t;

endpackage

// ----- rtl/one_wire_bus_master.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Single-wire bus master: open-drain timing, presence detect, byte read/write.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          content
//  s_*       in   s_tvalid/s_tready  tick with bus level, or command
//  m_*       out  m_tvalid/m_tready  drive/status/result, one per request
//  cfg_*     in   cfg_we             timing register write, no read-back
//
//  Each request is processed in the cycle it is accepted; its result sits in
//  the output register the next cycle. One request per cycle is sustained while m_tready is high.
//  s_tready falls only while a result waits and m_tready is low.
//  rst (synchronous) restores idle state and the default timing registers.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
  parameter int TIMER_BITS = owb_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [owb_pkg::S_TDATA_W-1:0]   s_tdata,   // tx_byte[7:0], bus_level[8]
  input  logic [1:0]                      s_tuser,   // func[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [owb_pkg::M_TDATA_W-1:0]   m_tdata,   // drive_low[0], busy_res[1],
                                                     // done_res[2], presence[3],
                                                     // rx_byte[11:4], cmd_rejected[12]
  input  logic                            cfg_we,
  input  logic [owb_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [owb_pkg::REG_W-1:0]       cfg_wdata
);

  owb_pkg::cfg_t    cfg;
  owb_pkg::result_t result;
  owb_pkg::result_t out_res;
  logic             accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time    <= owb_pkg::RST_RESET_LOW;
      cfg.presence_wait     <= owb_pkg::RST_PRES_WAIT;
      cfg.reset_tail        <= owb_pkg::RST_RESET_TAIL;
      cfg.short_low_time    <= owb_pkg::RST_SHORT_LOW;
      cfg.write_one_release <= owb_pkg::RST_W1_RELEASE;
      cfg.write_zero_low    <= owb_pkg::RST_W0_LOW;
      cfg.zero_recovery     <= owb_pkg::RST_ZERO_REC;
      cfg.read_sample_wait  <= owb_pkg::RST_RD_WAIT;
    end else if (cfg_we) begin
      case (owb_pkg::reg_idx_t'(cfg_addr))
        owb_pkg::REG_RESET_LOW:  cfg.reset_low_time    <= cfg_wdata;
        owb_pkg::REG_PRES_WAIT:  cfg.presence_wait     <= cfg_wdata;
        owb_pkg::REG_RESET_TAIL: cfg.reset_tail        <= cfg_wdata;
        owb_pkg::REG_SHORT_LOW:  cfg.short_low_time    <= cfg_wdata;
        owb_pkg::REG_W1_RELEASE: cfg.write_one_release <= cfg_wdata;
        owb_pkg::REG_W0_LOW:     cfg.write_zero_low    <= cfg_wdata;
        owb_pkg::REG_ZERO_REC:   cfg.zero_recovery     <= cfg_wdata;
        owb_pkg::REG_RD_WAIT:    cfg.read_sample_wait  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  owb_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .func      (owb_pkg::func_t'(s_tuser)),
    .tx_byte   (s_tdata[owb_pkg::BYTE_W-1:0]),
    .bus_level (s_tdata[owb_pkg::BYTE_W]),
    .cfg       (cfg),
    .result    (result)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= result;
    end
  end

  assign m_tdata = {3'b000, out_res.cmd_rejected, out_res.rx_byte, out_res.presence,
                    out_res.done_res, out_res.busy_res, out_res.drive_low};

`ifndef SYNTH
  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(out_res))
    else $error("pending result lost or changed under stall");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !accept)
    else $error("request accepted while output register full");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.done_res && out_res.busy_res))
    else $error("done and busy reported together");
`endif

endmodule

// ----- rtl/owb_engine.sv -----
// ----------------------------------------------------------------------------
// owb_engine
// Bus timing state: phase, interval timer, bit counter and shift register.
// Computes the next state and the result for one request combinationally.
// ----------------------------------------------------------------------------
module owb_engine #(
  parameter int TIMER_BITS = owb_pkg::TIMER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  owb_pkg::func_t              func,
  input  logic [owb_pkg::BYTE_W-1:0]  tx_byte,
  input  logic                        bus_level,
  input  owb_pkg::cfg_t               cfg,
  output owb_pkg::result_t            result
);

  localparam int CMP_W = (TIMER_BITS > owb_pkg::REG_W) ? TIMER_BITS : owb_pkg::REG_W;
  localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'((1 << TIMER_BITS) - 1);
  localparam logic [owb_pkg::BIT_IDX_W-1:0] LAST_BIT =
    owb_pkg::BIT_IDX_W'(owb_pkg::BYTE_W - 1);

  function automatic logic [TIMER_BITS-1:0] sat_len(input logic [owb_pkg::REG_W-1:0] len);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(len);
    if (wide > TIMER_MAX) begin
      wide = TIMER_MAX;
    end
    return TIMER_BITS'(wide);
  endfunction

  owb_pkg::phase_t                  phase, phase_next;
  logic [TIMER_BITS-1:0]            interval_count, interval_count_next;
  logic [owb_pkg::BIT_IDX_W-1:0]    bit_index, bit_index_next;
  logic [owb_pkg::BYTE_W-1:0]       shift_data, shift_data_next;
  logic                             presence_seen, presence_seen_next;
  logic [owb_pkg::BYTE_W-1:0]       read_result, read_result_next;
  logic                             done, rejected;
  logic [owb_pkg::REG_W-1:0]        read_tail;
  logic [owb_pkg::BIT_IDX_W-1:0]    bit_inc;

  assign read_tail = (cfg.write_one_release > cfg.read_sample_wait) ?
                     (cfg.write_one_release - cfg.read_sample_wait) : '0;
  assign bit_inc   = bit_index + owb_pkg::BIT_IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= owb_pkg::PH_IDLE;
      interval_count <= '0;
      bit_index      <= '0;
      shift_data     <= '0;
      presence_seen  <= 1'b0;
      read_result    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      interval_count <= interval_count_next;
      bit_index      <= bit_index_next;
      shift_data     <= shift_data_next;
      presence_seen  <= presence_seen_next;
      read_result    <= read_result_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    interval_count_next = interval_count;
    bit_index_next      = bit_index;
    shift_data_next     = shift_data;
    presence_seen_next  = presence_seen;
    read_result_next    = read_result;
    done                = 1'b0;
    rejected            = 1'b0;

    if (func == owb_pkg::FUNC_TICK) begin
      if (phase != owb_pkg::PH_IDLE) begin
        if (interval_count > TIMER_BITS'(1)) begin
          interval_count_next = interval_count - TIMER_BITS'(1);
        end else begin
          case (phase)
            owb_pkg::PH_RST_LOW: begin
              phase_next          = owb_pkg::PH_RST_WAIT;
              interval_count_next = sat_len(cfg.presence_wait);
            end
            owb_pkg::PH_RST_WAIT: begin
              presence_seen_next  = ~bus_level;
              phase_next          = owb_pkg::PH_RST_TAIL;
              interval_count_next = sat_len(cfg.reset_tail);
            end
            owb_pkg::PH_RST_TAIL: begin
              phase_next          = owb_pkg::PH_IDLE;
              interval_count_next = '0;
              done                = 1'b1;
            end
            owb_pkg::PH_W1_LOW: begin
              phase_next          = owb_pkg::PH_W1_REL;
              interval_count_next = sat_len(cfg.write_one_release);
            end
            owb_pkg::PH_W0_LOW: begin
              phase_next          = owb_pkg::PH_W0_REC;
              interval_count_next = sat_len(cfg.zero_recovery);
            end
            owb_pkg::PH_W1_REL, owb_pkg::PH_W0_REC: begin
              if (bit_index == LAST_BIT) begin
                bit_index_next      = '0;
                phase_next          = owb_pkg::PH_IDLE;
                interval_count_next = '0;
                done                = 1'b1;
              end else begin
                bit_index_next = bit_inc;
                // open the next write slot from the next data bit
                if (shift_data[bit_inc]) begin
                  phase_next          = owb_pkg::PH_W1_LOW;
                  interval_count_next = sat_len(cfg.short_low_time);
                end else begin
                  phase_next          = owb_pkg::PH_W0_LOW;
                  interval_count_next = sat_len(cfg.write_zero_low);
                end
              end
            end
            owb_pkg::PH_RD_LOW: begin
              phase_next          = owb_pkg::PH_RD_WAIT;
              interval_count_next = sat_len(cfg.read_sample_wait);
            end
            owb_pkg::PH_RD_WAIT: begin
              if (bus_level) begin
                shift_data_next[bit_index] = 1'b1;
              end
              phase_next          = owb_pkg::PH_RD_TAIL;
              interval_count_next = sat_len(read_tail);
            end
            owb_pkg::PH_RD_TAIL: begin
              if (bit_index == LAST_BIT) begin
                bit_index_next      = '0;
                read_result_next    = shift_data;
                phase_next          = owb_pkg::PH_IDLE;
                interval_count_next = '0;
                done                = 1'b1;
              end else begin
                bit_index_next      = bit_inc;
                phase_next          = owb_pkg::PH_RD_LOW;
                interval_count_next = sat_len(cfg.short_low_time);
              end
            end
            default: begin
              phase_next          = owb_pkg::PH_IDLE;
              interval_count_next = '0;
            end
          endcase
        end
      end
    end else if (phase != owb_pkg::PH_IDLE) begin
      rejected = 1'b1;
    end else begin
      bit_index_next = '0;
      case (func)
        owb_pkg::FUNC_RESET: begin
          phase_next          = owb_pkg::PH_RST_LOW;
          interval_count_next = sat_len(cfg.reset_low_time);
        end
        owb_pkg::FUNC_WRITE: begin
          shift_data_next = tx_byte;
          if (tx_byte[0]) begin
            phase_next          = owb_pkg::PH_W1_LOW;
            interval_count_next = sat_len(cfg.short_low_time);
          end else begin
            phase_next          = owb_pkg::PH_W0_LOW;
            interval_count_next = sat_len(cfg.write_zero_low);
          end
        end
        default: begin
          shift_data_next     = '0;
          phase_next          = owb_pkg::PH_RD_LOW;
          interval_count_next = sat_len(cfg.short_low_time);
        end
      endcase
    end
  end

  always_comb begin
    result.drive_low    = (phase_next == owb_pkg::PH_RST_LOW) ||
                          (phase_next == owb_pkg::PH_W1_LOW)  ||
                          (phase_next == owb_pkg::PH_W0_LOW)  ||
                          (phase_next == owb_pkg::PH_RD_LOW);
    result.busy_res     = (phase_next != owb_pkg::PH_IDLE);
    result.done_res     = done;
    result.presence     = presence_seen_next;
    result.rx_byte      = read_result_next;
    result.cmd_rejected = rejected;
  end

`ifndef SYNTH
  // a finished command leaves the engine idle with the bit counter cleared
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && done |=> (phase == owb_pkg::PH_IDLE) && (bit_index == '0))
    else $error("command finished but engine not idle");

  // a rejected request must not disturb timing
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    step && rejected |=> $stable(phase) && $stable(interval_count) && $stable(bit_index))
    else $error("rejected request changed engine state");

  // idle engine keeps its counters at rest
  a_idle_rest: assert property (@(posedge clk) disable iff (rst)
    phase == owb_pkg::PH_IDLE |-> (bit_index == '0) && (interval_count == '0))
    else $error("idle engine with live counters");

  // the read byte only moves when a read finishes
  a_rx_update: assert property (@(posedge clk) disable iff (rst)
    step && !(done && (phase == owb_pkg::PH_RD_TAIL)) |=> $stable(read_result))
    else $error("read result changed outside read completion");
`endif

endmodule
